// ===== hw/rtl/gvd_pkg.sv =====
// shared types and constants of the grid vertical difference block
`default_nettype none
package gvd_pkg;

    // fixed field widths
    localparam int SAMPLE_W    = 32;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int DIM_W       = 7;
    localparam int STEP_W      = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [DIM_W-1:0]  DIM_RESET  = 7'd16;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'd65536;

    // register word indexes
    typedef enum logic [1:0] {
        REG_ROW_LENGTH   = 2'd0,
        REG_ROW_COUNT    = 2'd1,
        REG_INVERSE_STEP = 2'd2
    } t_reg_idx;

    // geometry seen by the front end
    typedef struct packed {
        logic [DIM_W-1:0] row_length;
        logic [DIM_W-1:0] row_count;
        logic             restart;
    } t_geom;

    // one classified sample handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] first_ref;
        logic signed [SAMPLE_W-1:0] second_ref;
        logic                       half;
        logic                       pair;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
    } t_job;

endpackage
`default_nettype wire

// ===== hw/rtl/gvd_if.sv =====
// stream channels for samples and results
`default_nettype none
interface gvd_sample_if;
    import gvd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface gvd_result_if;
    import gvd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] derivative;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_column;
    logic                       clipped;
    logic                       last_of_run;
    modport source (output valid, output derivative, output out_row, output out_column,
                    output clipped, output last_of_run, input ready);
    modport sink   (input valid, input derivative, input out_row, input out_column,
                    input clipped, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/grid_vertical_difference_top.sv =====
// Vertical derivative of a row-major grid stream with two line buffers.
// Path: a result passes the stage-one register, the queue, stage a, stage b and the output
// register once its sample is taken; a last-row sample's second result follows its first.
// Throughput: one sample per cycle while results are taken; on the last row each sample makes
// two results in the one multiplier, so once the 4-word queue fills the intake falls behind.
// Reset: synchronous active low; registers go to 16, 16 and 1.0, the grid position to
// the origin, line buffers are not cleared.
`default_nettype none
module grid_vertical_difference_top #(
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROWS       = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    gvd_sample_if.sink                              i_samples,
    gvd_result_if.source                            o_results,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [gvd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [gvd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [gvd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);
    import gvd_pkg::*;

    logic [DIM_W-1:0]  r_row_length;
    logic [DIM_W-1:0]  r_row_count;
    logic [STEP_W-1:0] r_step;
    logic              wr;
    t_reg_idx          idx;
    t_geom             geom;
    logic              push;
    t_job              push_job;
    logic              full;
    logic              head_valid;
    t_job              head_job;
    logic              pop;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = t_reg_idx'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= DIM_RESET;
            r_row_count  <= DIM_RESET;
            r_step       <= STEP_RESET;
        end else if (wr) begin
            case (idx)
                REG_ROW_LENGTH:   r_row_length <= pwdata[DIM_W-1:0];
                REG_ROW_COUNT:    r_row_count  <= pwdata[DIM_W-1:0];
                REG_INVERSE_STEP: r_step       <= pwdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (idx)
            REG_ROW_LENGTH:   prdata = APB_DATA_W'(r_row_length);
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_row_count);
            REG_INVERSE_STEP: prdata = APB_DATA_W'(r_step);
            default:          prdata = '0;
        endcase
    end

    // geometry writes restart the grid
    always_comb begin
        geom.row_length = r_row_length;
        geom.row_count  = r_row_count;
        geom.restart    = wr && (idx == REG_ROW_LENGTH || idx == REG_ROW_COUNT);
    end

    gvd_front #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_samples (i_samples),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    gvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    gvd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (head_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .i_step    (r_step),
        .o_results (o_results)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/gvd_ram.sv =====
// simple dual port ram with registered read
`default_nettype none
module gvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== hw/rtl/gvd_front.sv =====
// front end: grid position tracking, line buffers and classification
`default_nettype none
module gvd_front #(
    parameter int MAX_ROW_LENGTH = 64,
    parameter int MAX_ROWS       = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gvd_pkg::t_geom i_geom,
    gvd_sample_if.sink         i_samples,
    input  wire logic          i_full,
    output logic               o_push,
    output gvd_pkg::t_job      o_job
);
    import gvd_pkg::*;

    localparam int CW     = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    logic [LEN_W-1:0]           len;
    logic [ROWS_W-1:0]          rows;
    logic                       col_last;
    logic                       row_last;
    logic                       accept;
    logic                       s1_has;
    logic                       s1_go;
    logic [CW-1:0]              r_col;
    logic [RW-1:0]              r_row;
    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic [CW-1:0]              r_x1;
    logic [RW-1:0]              r_y1;
    logic                       r_last1;
    logic [SAMPLE_W-1:0]        newer_rd;
    logic [SAMPLE_W-1:0]        older_rd;

    // clamp geometry to the supported range
    always_comb begin
        if (i_geom.row_length < DIM_W'(2)) begin
            len = LEN_W'(2);
        end else if (int'(i_geom.row_length) > MAX_ROW_LENGTH) begin
            len = LEN_W'(MAX_ROW_LENGTH);
        end else begin
            len = LEN_W'(i_geom.row_length);
        end
        if (i_geom.row_count < DIM_W'(2)) begin
            rows = ROWS_W'(2);
        end else if (int'(i_geom.row_count) > MAX_ROWS) begin
            rows = ROWS_W'(MAX_ROWS);
        end else begin
            rows = ROWS_W'(i_geom.row_count);
        end
    end

    assign col_last = (LEN_W'(r_col) + LEN_W'(1)) == len;
    assign row_last = (ROWS_W'(r_row) + ROWS_W'(1)) == rows;

    // handshake: stage one moves on unless it carries results and the queue is full
    assign s1_has          = r_y1 != '0;
    assign s1_go           = r_v1 && (!s1_has || !i_full);
    assign i_samples.ready = !r_v1 || s1_go;
    assign accept          = i_samples.valid && i_samples.ready;

    // position counters and stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (i_geom.restart) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1    <= i_samples.sample;
            r_x1    <= r_col;
            r_y1    <= r_row;
            r_last1 <= row_last;
        end
    end

    // line buffers: read at accept, update when stage one leaves
    gvd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_x1),
        .i_wdata (r_s1),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (newer_rd)
    );

    gvd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_x1),
        .i_wdata (newer_rd),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (older_rd)
    );

    // classify: second row uses a one-sided difference, later rows a central one
    always_comb begin
        o_job.sample     = r_s1;
        o_job.first_ref  = (r_y1 == RW'(1)) ? newer_rd : older_rd;
        o_job.second_ref = newer_rd;
        o_job.half       = r_y1 != RW'(1);
        o_job.pair       = r_last1;
        o_job.row        = ROW_W'(r_y1);
        o_job.col        = COL_W'(r_x1);
    end

    assign o_push = s1_go && s1_has;

    // the top row only fills the buffers
    a_top_row_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_v1 && r_y1 != '0))
        else $error("front pushed a word for the top row");
endmodule
`default_nettype wire

// ===== hw/rtl/gvd_queue.sv =====
// short queue between front and back
`default_nettype none
module gvd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gvd_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    output gvd_pkg::t_job      o_job,
    input  wire logic          i_pop
);
    import gvd_pkg::*;

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_job   = r_slot[r_rp];
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill level out of range");
endmodule
`default_nettype wire

// ===== hw/rtl/gvd_back.sv =====
// back end: difference, scaling by the inverse step, rounding and saturation
`default_nettype none
module gvd_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire gvd_pkg::t_job              i_job,
    output logic                            o_pop,
    input  wire logic [gvd_pkg::STEP_W-1:0] i_step,
    gvd_result_if.source                    o_results
);
    import gvd_pkg::*;

    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int PROD_W = MAG_W + STEP_W;
    localparam int RES_W  = PROD_W + 1 - 16;
    localparam logic [RES_W-1:0] POS_LIM = RES_W'((64'(1) << (SAMPLE_W - 1)) - 64'(1));
    localparam logic [RES_W-1:0] NEG_LIM = RES_W'(64'(1) << (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0] POS_OUT = SAMPLE_W'(POS_LIM);
    localparam logic [SAMPLE_W-1:0] NEG_OUT = SAMPLE_W'(NEG_LIM);

    logic                       r_phase;
    logic                       take;
    logic signed [SAMPLE_W-1:0] ref_sel;
    logic signed [MAG_W-1:0]    diff;
    logic                       a_free;
    logic                       b_free;
    logic                       o_free;

    // stage a: magnitude of the difference
    logic                 r_a_v;
    logic [MAG_W-1:0]     r_a_mag;
    logic                 r_a_neg;
    logic                 r_a_half;
    logic [ROW_W-1:0]     r_a_row;
    logic [COL_W-1:0]     r_a_col;
    logic                 r_a_last;

    // stage b: full product
    logic                 r_b_v;
    logic [PROD_W-1:0]    r_b_prod;
    logic                 r_b_neg;
    logic                 r_b_half;
    logic [ROW_W-1:0]     r_b_row;
    logic [COL_W-1:0]     r_b_col;
    logic                 r_b_last;

    // output register
    logic                 r_o_v;
    logic [SAMPLE_W-1:0]  r_o_deriv;
    logic [ROW_W-1:0]     r_o_row;
    logic [COL_W-1:0]     r_o_col;
    logic                 r_o_clip;
    logic                 r_o_last;

    logic [PROD_W:0]      rounded_sum;
    logic [RES_W-1:0]     res;
    logic                 clip;
    logic [SAMPLE_W-1:0]  deriv;

    // flow control down the pipe
    assign o_free = !r_o_v || o_results.ready;
    assign b_free = !r_b_v || o_free;
    assign a_free = !r_a_v || b_free;
    assign take   = i_valid && a_free;
    assign o_pop  = take && (r_phase || !i_job.pair);

    // operand selection for the current result of the head word
    assign ref_sel = r_phase ? i_job.second_ref : i_job.first_ref;
    assign diff    = MAG_W'(i_job.sample) - MAG_W'(ref_sel);

    // phase: a last-row word gives a second result before it is popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= !r_phase && i_job.pair;
            end
            if (a_free) begin
                r_a_v <= take;
            end
            if (b_free) begin
                r_b_v <= r_a_v;
            end
            if (o_free) begin
                r_o_v <= r_b_v;
            end
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_neg  <= diff[MAG_W-1];
            r_a_mag  <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
            r_a_half <= r_phase ? 1'b0 : i_job.half;
            r_a_row  <= r_phase ? i_job.row : i_job.row - ROW_W'(1);
            r_a_col  <= i_job.col;
            r_a_last <= r_phase || !i_job.pair;
        end
    end

    // stage b payload: one multiplier
    always_ff @(posedge i_clk) begin
        if (r_a_v && b_free) begin
            r_b_prod <= PROD_W'(r_a_mag) * PROD_W'(i_step);
            r_b_neg  <= r_a_neg;
            r_b_half <= r_a_half;
            r_b_row  <= r_a_row;
            r_b_col  <= r_a_col;
            r_b_last <= r_a_last;
        end
    end

    // round half away from zero on the magnitude, then saturate
    always_comb begin
        if (r_b_half) begin
            rounded_sum = {1'b0, r_b_prod} + (PROD_W + 1)'(1 << 16);
            res         = RES_W'(rounded_sum >> 17);
        end else begin
            rounded_sum = {1'b0, r_b_prod} + (PROD_W + 1)'(1 << 15);
            res         = RES_W'(rounded_sum >> 16);
        end
        if (r_b_neg) begin
            clip  = res > NEG_LIM;
            deriv = clip ? NEG_OUT : SAMPLE_W'(-res[SAMPLE_W-1:0]);
        end else begin
            clip  = res > POS_LIM;
            deriv = clip ? POS_OUT : res[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_b_v && o_free) begin
            r_o_deriv <= deriv;
            r_o_row   <= r_b_row;
            r_o_col   <= r_b_col;
            r_o_clip  <= clip;
            r_o_last  <= r_b_last;
        end
    end

    assign o_results.valid       = r_o_v;
    assign o_results.derivative  = r_o_deriv;
    assign o_results.out_row     = r_o_row;
    assign o_results.out_column  = r_o_col;
    assign o_results.clipped     = r_o_clip;
    assign o_results.last_of_run = r_o_last;

    a_phase_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_valid && i_job.pair))
        else $error("second result pending without a last-row word at the head");
    a_clip_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_results.valid && o_results.clipped) |->
        (o_results.derivative == POS_OUT || o_results.derivative == NEG_OUT))
        else $error("clipped word without a saturated derivative");
endmodule
`default_nettype wire

// ===== tb/sv/gvd_checker.sv =====
// monitor, line-buffer predictor and scoreboard for the grid vertical difference block
`default_nettype none
module gvd_checker
    import gvd_pkg::*;
#(
    parameter int GRID_MAX = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    gvd_sample_if                      i_samples,
    gvd_result_if                      i_results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    // one derivative word as the block should deliver it
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] derivative;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           column;
        logic                       clipped;
        logic                       last_of_run;
    } slope_t;

    slope_t                     expected_slopes[$];

    // shadow registers and grid position
    logic [DIM_W-1:0]           row_length;
    logic [DIM_W-1:0]           row_count;
    logic [STEP_W-1:0]          inverse_step;
    logic signed [SAMPLE_W-1:0] two_above[GRID_MAX];
    logic signed [SAMPLE_W-1:0] one_above[GRID_MAX];
    int unsigned                column_pos;
    int unsigned                row_pos;

    // geometry outside 2..max is pinned to the nearest end
    function automatic int unsigned used_dim(input logic [DIM_W-1:0] raw);
        if (raw < 2) return 2;
        if (raw > GRID_MAX) return GRID_MAX;
        return 32'(raw);
    endfunction

    // (lower - upper) * inverse_step, halved for a central difference,
    // rounded half away from zero, then saturated to the sample range
    function automatic slope_t scaled_difference(
        input logic signed [SAMPLE_W-1:0] lower,
        input logic signed [SAMPLE_W-1:0] upper,
        input bit                         central,
        input int unsigned                row,
        input int unsigned                column,
        input bit                         last
    );
        longint      diff;
        logic [32:0] magnitude;
        logic [66:0] rounded;
        logic [66:0] limit;
        slope_t      slope;
        diff = longint'(lower) - longint'(upper);
        magnitude = (diff < 0) ? 33'(-diff) : 33'(diff);
        rounded = 67'(magnitude) * 67'(inverse_step);
        if (central) begin
            rounded = (rounded + (67'd1 << 16)) >> 17;
        end else begin
            rounded = (rounded + (67'd1 << 15)) >> 16;
        end
        limit = 67'd1 << (SAMPLE_W - 1);
        if (diff < 0) begin
            slope.clipped = (rounded > limit);
            if (slope.clipped) rounded = limit;
            slope.derivative = SAMPLE_W'(67'd0 - rounded);
        end else begin
            slope.clipped = (rounded >= limit);
            if (slope.clipped) rounded = limit - 67'd1;
            slope.derivative = SAMPLE_W'(rounded);
        end
        slope.row = ROW_W'(row);
        slope.column = COL_W'(column);
        slope.last_of_run = last;
        return slope;
    endfunction

    // a sample finishes the point above it, and on the last row its own point too
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] value);
        int unsigned                len;
        int unsigned                rows;
        int unsigned                x;
        int unsigned                y;
        logic signed [SAMPLE_W-1:0] above;
        logic signed [SAMPLE_W-1:0] above2;
        bit                         last_row;
        len = used_dim(row_length);
        rows = used_dim(row_count);
        x = column_pos;
        y = row_pos;
        above = one_above[x];
        above2 = two_above[x];
        if (y >= 1) begin
            last_row = (y == rows - 1);
            if (y == 1) begin
                expected_slopes.push_back(scaled_difference(value, above, 1'b0, 0, x, !last_row));
            end else begin
                expected_slopes.push_back(scaled_difference(value, above2, 1'b1, y - 1, x,
                                                            !last_row));
            end
            if (last_row) begin
                expected_slopes.push_back(scaled_difference(value, above, 1'b0, y, x, 1'b1));
            end
        end
        two_above[x] = above;
        one_above[x] = value;
        if (x + 1 >= len) begin
            column_pos = 0;
            row_pos = (y + 1 >= rows) ? 0 : y + 1;
        end else begin
            column_pos = x + 1;
        end
    endtask

    // result word against the oldest prediction
    task automatic check_result();
        slope_t want;
        if (expected_slopes.size() == 0) begin
            $error("unexpected derivative %0d at row %0d column %0d",
                   i_results.derivative, i_results.out_row, i_results.out_column);
            o_mismatches++;
        end else begin
            want = expected_slopes.pop_front();
            if (i_results.derivative !== want.derivative) begin
                $error("derivative: expected %0d, got %0d", want.derivative,
                       i_results.derivative);
                o_mismatches++;
            end
            if (i_results.out_row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, i_results.out_row);
                o_mismatches++;
            end
            if (i_results.out_column !== want.column) begin
                $error("out_column: expected %0d, got %0d", want.column, i_results.out_column);
                o_mismatches++;
            end
            if (i_results.clipped !== want.clipped) begin
                $error("clipped: expected %0d, got %0d", want.clipped, i_results.clipped);
                o_mismatches++;
            end
            if (i_results.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                       i_results.last_of_run);
                o_mismatches++;
            end
        end
    endtask

    // sample at the falling edge: every handshake seen here completes at the next rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            row_length = DIM_RESET;
            row_count = DIM_RESET;
            inverse_step = STEP_RESET;
            column_pos = 0;
            row_pos = 0;
            for (int i = 0; i < GRID_MAX; i++) begin
                two_above[i] = '0;
                one_above[i] = '0;
            end
            expected_slopes.delete();
            o_mismatches = 0;
        end else begin
            // register writes; a geometry write restarts the grid
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_ROW_LENGTH: begin
                        row_length = pwdata[DIM_W-1:0];
                        column_pos = 0;
                        row_pos = 0;
                    end
                    REG_ROW_COUNT: begin
                        row_count = pwdata[DIM_W-1:0];
                        column_pos = 0;
                        row_pos = 0;
                    end
                    REG_INVERSE_STEP: begin
                        inverse_step = pwdata[STEP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_samples.valid && i_samples.ready) take_sample(i_samples.sample);
            if (i_results.valid && i_results.ready) check_result();
        end
        o_outstanding = expected_slopes.size();
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// stimulus, flow control and verdict for the grid vertical difference block
`default_nettype none
module tb;
    import gvd_pkg::*;

    localparam int                    GRID_MAX     = 64;
    localparam logic [1:0]            REG_UNUSED   = 2'd3;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_MAX   = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0]   SAMPLE_MIN   = 32'h8000_0000;
    localparam int                    DRAIN_CYCLES = 12;
    localparam int                    WORD_TARGET  = 1824;
    localparam int                    PRESSURE_AT  = 1300;
    localparam int                    LONG_HOLD    = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    outstanding;
    int unsigned           words_sent;
    int unsigned           sender_idle_pct;
    int unsigned           receiver_idle_pct;
    int unsigned           grid_words;

    gvd_sample_if sample_ch();
    gvd_result_if result_ch();

    grid_vertical_difference_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (sample_ch),
        .o_results (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    gvd_checker #(.GRID_MAX(GRID_MAX)) slope_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_samples     (sample_ch),
        .i_results     (result_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // hard stop
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // grid size actually used for a raw register value
    function automatic int unsigned used_side(input logic [DIM_W-1:0] raw);
        if (raw < 2) return 2;
        if (raw > GRID_MAX) return GRID_MAX;
        return 32'(raw);
    endfunction

    // mostly small grids, now and then the extremes and out of range values
    function automatic logic [DIM_W-1:0] random_side();
        case ($urandom_range(19))
            0:       return DIM_W'(0);
            1:       return DIM_W'(1);
            2:       return DIM_W'(GRID_MAX);
            3:       return DIM_W'($urandom_range(GRID_MAX + 1, 127));
            4, 5:    return DIM_W'($urandom_range(9, 20));
            default: return DIM_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] random_step();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return STEP_RESET;
            4, 5, 6: return $urandom_range(1, 1 << 18);
            default: return $urandom();
        endcase
    endfunction

    // full scale, extremes, and small values from -2^20 to 2^20
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return $urandom();
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    // apb write: setup, then access until pready, then back to idle
    task automatic write_reg(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // all three registers, with junk above the geometry fields
    task automatic set_grid(input logic [DIM_W-1:0] raw_len, input logic [DIM_W-1:0] raw_rows,
                            input logic [STEP_W-1:0] step);
        logic [31:0] junk;
        junk = $urandom();
        write_reg(REG_ROW_LENGTH, {junk[31:DIM_W], raw_len});
        junk = $urandom();
        write_reg(REG_ROW_COUNT, {junk[31:DIM_W], raw_rows});
        write_reg(REG_INVERSE_STEP, step);
        grid_words = used_side(raw_len) * used_side(raw_rows);
    endtask

    // one sample word, with random gaps before it
    task automatic send_word(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= value;
        do @(negedge i_clk); while (!sample_ch.ready);
        @(posedge i_clk);
        words_sent <= words_sent + 1;
    endtask

    // stop sending, collect every predicted word, let row-0 samples clear the pipe
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls plus one long hold while samples keep coming
    initial begin
        int unsigned hold_left;
        bit          long_hold_done;
        hold_left = 0;
        long_hold_done = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                result_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (!long_hold_done && words_sent >= PRESSURE_AT && sample_ch.valid) begin
                result_ch.ready <= 1'b0;
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // reset, directed grids, random grids, verdict
    initial begin
        logic [DIM_W-1:0] raw_len;
        logic [DIM_W-1:0] raw_rows;
        int unsigned      words;
        sample_ch.valid = 1'b0;
        sample_ch.sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        words_sent = 0;
        grid_words = 0;
        sender_idle_pct = 19;
        receiver_idle_pct = 74;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // forward, central and backward differences at full scale, saturating both ways
        set_grid(2, 3, 32'hFFFF_FFFF);
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        send_word(SAMPLE_MIN);
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MAX);
        send_word(SAMPLE_MIN);
        wait_idle();

        // geometry below the minimum, zero step
        set_grid(1, 0, '0);
        repeat (4) send_word(random_sample());
        wait_idle();

        // half step: ties round away from zero; write to an unmapped address
        set_grid(2, 2, 32'h0000_8000);
        write_reg(REG_UNUSED, $urandom());
        send_word(0);
        send_word(0);
        send_word(1);
        send_word(-1);
        wait_idle();

        // row count rewritten part way through a grid
        set_grid(3, 4, STEP_RESET);
        repeat (4) send_word(random_sample());
        wait_idle();
        write_reg(REG_ROW_COUNT, {(APB_DATA_W - DIM_W)'($urandom() >> DIM_W), 7'd2});
        repeat (6) send_word(random_sample());
        wait_idle();

        // random grids, one or more whole grids per setting, sometimes a partial one
        while (words_sent < WORD_TARGET) begin
            raw_len = random_side();
            if (used_side(raw_len) > 20) begin
                raw_rows = DIM_W'($urandom_range(0, 3));
            end else begin
                raw_rows = random_side();
                if (used_side(raw_rows) > 20 && used_side(raw_len) > 3) begin
                    raw_len = DIM_W'($urandom_range(0, 3));
                end
            end
            set_grid(raw_len, raw_rows, random_step());
            words = grid_words * (1 + $urandom_range(0, 96 / grid_words));
            if ($urandom_range(3) == 0) words += $urandom_range(1, grid_words - 1);
            repeat (words) send_word(random_sample());
            wait_idle();
            // swap the idle profile, then run with no idling
            if (words_sent >= 1200) begin
                sender_idle_pct <= 0;
                receiver_idle_pct <= 0;
            end else if (words_sent >= 600) begin
                sender_idle_pct <= 74;
                receiver_idle_pct <= 19;
            end
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
